### sv/ads_pkg.sv
// Shared types, constants and register codes of the accessory discovery screener.
`default_nettype none

package ads_pkg;

    localparam int ADS_BLOCK_ENTRIES = 8;
    localparam int ADS_SLOT_COUNT    = 4;
    localparam int QUEUE_DEPTH       = 2;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int RTC_W       = 24;
    localparam int ID_W        = 32;
    localparam int ENTRY_W     = ID_W + RTC_W;

    localparam logic [3:0] FAR_MAX     = 4'd15;
    localparam logic [4:0] HS_MAX      = 5'd31;
    localparam logic [4:0] ANNOUNCE_AT = 5'd25;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FILTER_MODE   = 3'd0,
        CFG_MATCH_DEVICE  = 3'd1,
        CFG_LINK_EN       = 3'd2,
        CFG_SIG_LIMIT     = 3'd3,
        CFG_FAR_LIMIT     = 3'd4,
        CFG_BLOCK_TICKS   = 3'd5,
        CFG_ACCEL_LIMIT   = 3'd6,
        CFG_ONE_G         = 3'd7
    } t_cfg_addr;

    typedef enum logic [1:0] {
        MODE_DISABLED  = 2'd0,
        MODE_ADVERTISE = 2'd1,
        MODE_PASS_ALL  = 2'd2,
        MODE_MATCH_ONE = 2'd3
    } t_filter_mode;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_ASSIGN   = 3'd1,
        ACT_REPORT   = 3'd2,
        ACT_LIGHTS   = 3'd3,
        ACT_ANNOUNCE = 3'd4,
        ACT_RELEASE  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        COLOR_WHITE = 2'd0,
        COLOR_GREEN = 2'd1,
        COLOR_RED   = 2'd2
    } t_color;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_CONNECT = 2'd1,
        KIND_SCAN    = 2'd2,
        KIND_PROP    = 2'd3
    } t_kind;

    localparam logic [1:0]       RST_FILTER_MODE   = 2'd0;
    localparam logic [7:0]       RST_MATCH_DEVICE  = 8'd0;
    localparam logic             RST_LINK_EN       = 1'b1;
    localparam logic [7:0]       RST_SIG_LIMIT     = 8'd59;
    localparam logic [3:0]       RST_FAR_LIMIT     = 4'd5;
    localparam logic [RTC_W-1:0] RST_BLOCK_TICKS   = 24'd9831;
    localparam logic [7:0]       RST_ACCEL_LIMIT   = 8'd7;
    localparam logic [6:0]       RST_ONE_G         = 7'd32;

    typedef struct packed {
        logic [1:0]       filter_mode;
        logic [7:0]       match_device;
        logic             link_en;
        logic [7:0]       sig_limit;
        logic [3:0]       far_limit;
        logic [RTC_W-1:0] block_ticks;
        logic [7:0]       accel_limit;
        logic [6:0]       one_g;
    } t_cfg;

    typedef struct packed {
        t_kind            kind;
        logic [RTC_W-1:0] now;
        logic [7:0]       device;
        logic [ID_W-1:0]  id;
        logic [1:0]       slot;
        logic             far;
        t_color           color;
    } t_item;

    typedef struct packed {
        t_action         action;
        logic [1:0]      slot;
        logic [ID_W-1:0] id;
        logic [7:0]      device;
        t_color          color;
    } t_result;

endpackage

`default_nettype wire

### sv/accessory_discovery_screener.sv
// Top level of the accessory discovery screener: registers, front end, queue and back end.
// A connect, prop-state or rejected word goes through the queue and then the result register.
// A scan-mode discovery word walks the block list one entry per cycle through the single read
// port of the list RAM; its result is loaded from the done state after any block list writes.
// Throughput: one word per cycle for other traffic while the output is not stalled; the front
// accepts while the queue has room.
// Reset (synchronous, active low) empties the queue and block list and loads the register defaults.
`default_nettype none

module accessory_discovery_screener
    import ads_pkg::*;
#(
    parameter int BLOCK_ENTRIES = ADS_BLOCK_ENTRIES,
    parameter int SLOT_COUNT    = ADS_SLOT_COUNT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // rtc_now, dev_code, accessory_id, signal_level, slot_index, accel_x, accel_y, accel_z
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // req_type
    input  wire logic                   i_s_tuser,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // out_slot, out_id, out_device, tilt_color
    output logic      [OUT_TDATA_W-1:0] o_m_tdata,
    // action
    output logic      [2:0]             o_m_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg    r_cfg;
    t_item   w_front_item;
    t_item   w_q_item;
    logic    w_q_full;
    logic    w_q_vld;
    logic    w_q_pop;
    t_result w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_mode   <= RST_FILTER_MODE;
            r_cfg.match_device  <= RST_MATCH_DEVICE;
            r_cfg.link_en       <= RST_LINK_EN;
            r_cfg.sig_limit     <= RST_SIG_LIMIT;
            r_cfg.far_limit     <= RST_FAR_LIMIT;
            r_cfg.block_ticks   <= RST_BLOCK_TICKS;
            r_cfg.accel_limit   <= RST_ACCEL_LIMIT;
            r_cfg.one_g         <= RST_ONE_G;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_FILTER_MODE:   r_cfg.filter_mode   <= i_cfg_wdata[1:0];
                CFG_MATCH_DEVICE:  r_cfg.match_device  <= i_cfg_wdata[7:0];
                CFG_LINK_EN:       r_cfg.link_en       <= i_cfg_wdata[0];
                CFG_SIG_LIMIT:     r_cfg.sig_limit     <= i_cfg_wdata[7:0];
                CFG_FAR_LIMIT:     r_cfg.far_limit     <= i_cfg_wdata[3:0];
                CFG_BLOCK_TICKS:   r_cfg.block_ticks   <= i_cfg_wdata[RTC_W-1:0];
                CFG_ACCEL_LIMIT:   r_cfg.accel_limit   <= i_cfg_wdata[7:0];
                CFG_ONE_G:         r_cfg.one_g         <= i_cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    ads_front #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_front (
        .i_tdata(i_s_tdata),
        .i_tuser(i_s_tuser),
        .i_cfg  (r_cfg),
        .o_item (w_front_item)
    );

    ads_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_s_tvalid),
        .i_item (w_front_item),
        .o_full (w_q_full),
        .o_vld  (w_q_vld),
        .o_item (w_q_item),
        .i_pop  (w_q_pop)
    );

    ads_back #(
        .BLOCK_ENTRIES(BLOCK_ENTRIES),
        .SLOT_COUNT   (SLOT_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_vld   (w_q_vld),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .i_m_tready(i_m_tready),
        .o_out_vld (o_m_tvalid),
        .o_out     (w_out)
    );

    assign o_s_tready = !w_q_full;
    assign o_m_tuser  = w_out.action;
    assign o_m_tdata  = {4'd0, w_out.color, w_out.device, w_out.id, w_out.slot};

endmodule

`default_nettype wire

### sv/ads_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module ads_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/ads_front.sv
// Front end: unpacks an input word and classifies it into a queue item.
`default_nettype none

module ads_front
    import ads_pkg::*;
#(
    parameter int SLOT_COUNT = ADS_SLOT_COUNT
) (
    input  wire logic [IN_TDATA_W-1:0] i_tdata,
    input  wire logic                  i_tuser,
    input  wire t_cfg                  i_cfg,
    output t_item                      o_item
);

    logic [RTC_W-1:0] w_now;
    logic [7:0]       w_dev;
    logic [ID_W-1:0]  w_id;
    logic [7:0]       w_sig;
    logic [1:0]       w_slot;
    logic [7:0]       w_ax;
    logic [7:0]       w_ay;
    logic [7:0]       w_az;
    logic [7:0]       w_rssi;
    logic [7:0]       w_max;
    logic [7:0]       w_maz;
    logic [8:0]       w_dy;
    logic [8:0]       w_dy_neg;
    logic [7:0]       w_may;
    logic             w_pass;

    assign w_now  = i_tdata[23:0];
    assign w_dev  = i_tdata[31:24];
    assign w_id   = i_tdata[63:32];
    assign w_sig  = i_tdata[71:64];
    assign w_slot = i_tdata[73:72];
    assign w_ax   = i_tdata[81:74];
    assign w_ay   = i_tdata[89:82];
    assign w_az   = i_tdata[97:90];

    assign w_rssi = w_sig[7] ? (~w_sig + 8'd1) : w_sig;
    assign w_max  = w_ax[7] ? (~w_ax + 8'd1) : w_ax;
    assign w_maz  = w_az[7] ? (~w_az + 8'd1) : w_az;
    assign w_dy     = {w_ay[7], w_ay} - {2'b00, i_cfg.one_g};
    assign w_dy_neg = ~w_dy + 9'd1;
    assign w_may    = w_dy[8] ? w_dy_neg[7:0] : w_dy[7:0];

    assign w_pass = (i_cfg.filter_mode == MODE_PASS_ALL)
                 || ((i_cfg.filter_mode == MODE_MATCH_ONE) && (w_dev == i_cfg.match_device));

    always_comb begin
        o_item.now    = w_now;
        o_item.device = w_dev;
        o_item.id     = w_id;
        o_item.slot   = w_slot;
        o_item.far    = w_rssi > i_cfg.sig_limit;
        if ((w_ax == 8'd0) && (w_ay == 8'd0) && (w_az == 8'd0)) begin
            o_item.color = COLOR_WHITE;
        end else if ((w_max < i_cfg.accel_limit) && (w_maz < i_cfg.accel_limit)
                     && (w_may < i_cfg.accel_limit)) begin
            o_item.color = COLOR_GREEN;
        end else begin
            o_item.color = COLOR_RED;
        end
        priority if (i_tuser) begin
            o_item.kind = (32'(w_slot) < SLOT_COUNT) ? KIND_PROP : KIND_NONE;
        end else if (!w_pass || (w_rssi >= i_cfg.sig_limit)) begin
            o_item.kind = KIND_NONE;
        end else if (i_cfg.link_en) begin
            o_item.kind = KIND_CONNECT;
        end else begin
            o_item.kind = KIND_SCAN;
        end
    end

endmodule

`default_nettype wire

### sv/ads_queue.sv
// Short queue of classified items between the front end and the back end.
`default_nettype none

module ads_queue
    import ads_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_vld,
    output t_item      o_item,
    input  wire logic  i_pop
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_item          r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full = r_cnt == (QAW+1)'(QUEUE_DEPTH);
    assign o_vld  = r_cnt != '0;
    assign o_item = r_mem[r_rd];
    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QAW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QAW'(1);
            end
            r_cnt <= r_cnt + (QAW+1)'(w_push) - (QAW+1)'(w_pop);
        end
    end

endmodule

`default_nettype wire

### sv/ads_back.sv
// Back end: block list scan, slot and handshake state, and the result register.
`default_nettype none

module ads_back
    import ads_pkg::*;
#(
    parameter int BLOCK_ENTRIES = ADS_BLOCK_ENTRIES,
    parameter int SLOT_COUNT    = ADS_SLOT_COUNT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_vld,
    input  wire t_item i_q_item,
    output logic       o_q_pop,
    input  wire logic  i_m_tready,
    output logic       o_out_vld,
    output t_result    o_out
);

    localparam int IW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_WR1  = 5'b00100,
        ST_WR2  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [BLOCK_ENTRIES-1:0] r_vld, n_vld;
    logic [3:0]          r_far [SLOT_COUNT];
    logic [3:0]          n_far [SLOT_COUNT];
    logic [4:0]          r_hs, n_hs;
    logic [ID_W-1:0]     r_linked, n_linked;
    logic                r_out_vld, n_out_vld;
    t_result             r_out, n_out;
    t_result             r_pend, n_pend;
    logic [ID_W-1:0]     r_cur_id, n_cur_id;
    logic [RTC_W-1:0]    r_cur_now, n_cur_now;
    logic [7:0]          r_cur_dev, n_cur_dev;
    logic [IW-1:0]       r_cmp_idx, n_cmp_idx;
    logic                r_have_e, n_have_e;
    logic [IW-1:0]       r_e_idx, n_e_idx;
    logic [IW-1:0]       r_w1_idx, n_w1_idx;
    logic [RTC_W-1:0]    r_w1_stamp, n_w1_stamp;
    logic [IW-1:0]       r_w2_idx, n_w2_idx;

    logic                w_out_free;
    logic                w_connect;
    logic                w_ram_we;
    logic [IW-1:0]       w_waddr;
    logic [ENTRY_W-1:0]  w_wdata;
    logic [IW-1:0]       w_raddr;
    logic [ENTRY_W-1:0]  w_rdata;
    logic [ID_W-1:0]     w_e_id;
    logic [RTC_W-1:0]    w_e_stamp;
    logic [RTC_W-1:0]    w_age;
    logic                w_hit;
    logic                w_stale;
    logic                w_last;
    logic [SW-1:0]       w_sidx;
    logic [3:0]          w_far_inc;
    logic [4:0]          w_hs_inc;
    t_result             w_report;

    ads_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(BLOCK_ENTRIES)
    ) u_block_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_out_free = !r_out_vld || i_m_tready;
    assign w_e_id     = r_vld[r_cmp_idx] ? w_rdata[ID_W-1:0] : '0;
    assign w_e_stamp  = r_vld[r_cmp_idx] ? w_rdata[ENTRY_W-1:ID_W] : '0;
    assign w_age      = r_cur_now - w_e_stamp;
    assign w_hit      = w_e_id == r_cur_id;
    assign w_stale    = w_age >= i_cfg.block_ticks;
    assign w_last     = r_cmp_idx == IW'(BLOCK_ENTRIES - 1);
    assign w_sidx     = SW'(i_q_item.slot);
    assign w_far_inc  = (r_far[w_sidx] == FAR_MAX) ? FAR_MAX : r_far[w_sidx] + 4'd1;
    assign w_hs_inc   = (r_hs == HS_MAX) ? HS_MAX : r_hs + 5'd1;

    always_comb begin
        w_report.action = ACT_REPORT;
        w_report.slot   = 2'd0;
        w_report.id     = r_cur_id;
        w_report.device = r_cur_dev;
        w_report.color  = COLOR_WHITE;
    end

    always_comb begin
        n_state    = r_state;
        n_vld      = r_vld;
        n_far      = r_far;
        n_hs       = r_hs;
        n_linked   = r_linked;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out      = r_out;
        n_pend     = r_pend;
        n_cur_id   = r_cur_id;
        n_cur_now  = r_cur_now;
        n_cur_dev  = r_cur_dev;
        n_cmp_idx  = r_cmp_idx;
        n_have_e   = r_have_e;
        n_e_idx    = r_e_idx;
        n_w1_idx   = r_w1_idx;
        n_w1_stamp = r_w1_stamp;
        n_w2_idx   = r_w2_idx;
        o_q_pop    = 1'b0;
        w_connect  = 1'b0;
        w_ram_we   = 1'b0;
        w_waddr    = r_w2_idx;
        w_wdata    = {r_cur_now, r_cur_id};
        w_raddr    = r_cmp_idx + IW'(1);

        unique case (r_state)
            ST_IDLE: begin
                w_raddr = '0;
                if (i_q_vld && (i_q_item.kind == KIND_SCAN)) begin
                    o_q_pop   = 1'b1;
                    n_cur_id  = i_q_item.id;
                    n_cur_now = i_q_item.now;
                    n_cur_dev = i_q_item.device;
                    n_cmp_idx = '0;
                    n_have_e  = 1'b0;
                    n_state   = ST_SCAN;
                end else if (i_q_vld && w_out_free) begin
                    o_q_pop   = 1'b1;
                    n_out_vld = 1'b1;
                    n_out     = '0;
                    unique case (i_q_item.kind)
                        KIND_CONNECT: begin
                            w_connect    = 1'b1;
                            n_hs         = '0;
                            n_linked     = i_q_item.id;
                            n_out.action = ACT_ASSIGN;
                            n_out.id     = i_q_item.id;
                        end
                        KIND_PROP: begin
                            n_out.slot = i_q_item.slot;
                            if (i_q_item.far) begin
                                n_far[w_sidx] = w_far_inc;
                            end else begin
                                n_far[w_sidx] = '0;
                            end
                            if (i_q_item.far && (w_far_inc > i_cfg.far_limit)) begin
                                n_out.action = ACT_RELEASE;
                            end else begin
                                n_hs        = w_hs_inc;
                                n_out.color = i_q_item.color;
                                if (w_hs_inc == ANNOUNCE_AT) begin
                                    n_out.action = ACT_ANNOUNCE;
                                    n_out.id     = r_linked;
                                end else begin
                                    n_out.action = ACT_LIGHTS;
                                end
                            end
                        end
                        default: begin
                            n_out.action = ACT_NONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_cmp_idx = r_cmp_idx + IW'(1);
                if (w_hit) begin
                    if (!w_stale) begin
                        n_pend  = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_pend = w_report;
                        if (r_have_e) begin
                            n_w1_idx   = r_cmp_idx;
                            n_w1_stamp = w_e_stamp;
                            n_w2_idx   = r_e_idx;
                            n_state    = ST_WR1;
                        end else begin
                            n_w2_idx = r_cmp_idx;
                            n_state  = ST_WR2;
                        end
                    end
                end else begin
                    if ((w_e_id == '0) && !r_have_e) begin
                        n_have_e = 1'b1;
                        n_e_idx  = r_cmp_idx;
                    end
                    if (w_last) begin
                        n_pend = w_report;
                        if (r_have_e) begin
                            n_w2_idx = r_e_idx;
                            n_state  = ST_WR2;
                        end else if (w_e_id == '0) begin
                            n_w2_idx = r_cmp_idx;
                            n_state  = ST_WR2;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_WR1: begin
                w_ram_we = 1'b1;
                w_waddr  = r_w1_idx;
                w_wdata  = {r_w1_stamp, {ID_W{1'b0}}};
                n_vld[r_w1_idx] = 1'b1;
                n_state  = ST_WR2;
            end
            ST_WR2: begin
                w_ram_we = 1'b1;
                n_vld[r_w2_idx] = 1'b1;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = r_pend;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_pend     <= n_pend;
        r_cur_id   <= n_cur_id;
        r_cur_now  <= n_cur_now;
        r_cur_dev  <= n_cur_dev;
        r_cmp_idx  <= n_cmp_idx;
        r_have_e   <= n_have_e;
        r_e_idx    <= n_e_idx;
        r_w1_idx   <= n_w1_idx;
        r_w1_stamp <= n_w1_stamp;
        r_w2_idx   <= n_w2_idx;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vld     <= '0;
            r_hs      <= '0;
            r_linked  <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_far[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_vld     <= n_vld;
            r_hs      <= n_hs;
            r_linked  <= n_linked;
            r_out_vld <= n_out_vld;
            r_far     <= n_far;
        end
    end

    assign o_out_vld = r_out_vld;
    assign o_out     = r_out;

    a_ram_write_only_in_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> ((r_state == ST_WR1) || (r_state == ST_WR2)))
        else $error("block list written outside a write state");

    a_pop_only_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == ST_IDLE))
        else $error("queue popped while an item is in progress");

    a_handshake_drops_only_on_connect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hs < $past(r_hs)) |-> $past(w_connect))
        else $error("handshake count dropped without a connect");

    a_scan_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR2) |=> (r_state == ST_DONE))
        else $error("insertion did not lead to the result stage");

endmodule

`default_nettype wire

### bench/tb_accessory_discovery_screener.sv
// Self-checking testbench for the accessory discovery screener against a predictor.
`timescale 1ns / 100ps

module tb_accessory_discovery_screener;
    import ads_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 600;
    localparam int STALL_LIMIT   = 5000;
    localparam int POOL_SIZE     = 12;

    typedef struct packed {
        logic              req;
        logic signed [7:0] az;
        logic signed [7:0] ay;
        logic signed [7:0] ax;
        logic [1:0]        slot;
        logic signed [7:0] rssi;
        logic [31:0]       id;
        logic [7:0]        dev;
        logic [23:0]       rtc;
    } t_acc_word;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [2:0]             o_m_tuser;
    logic                   o_m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    accessory_discovery_screener DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor copy of the registers.
    logic [1:0]  cfg_mode = RST_FILTER_MODE;
    logic [7:0]  cfg_match = RST_MATCH_DEVICE;
    logic        cfg_connect = RST_LINK_EN;
    logic [7:0]  cfg_sig_limit = RST_SIG_LIMIT;
    logic [3:0]  cfg_far_limit = RST_FAR_LIMIT;
    logic [23:0] cfg_ticks = RST_BLOCK_TICKS;
    logic [7:0]  cfg_accel_limit = RST_ACCEL_LIMIT;
    logic [6:0]  cfg_one_g = RST_ONE_G;

    // Predictor copy of the state.
    logic [31:0] blk_id [ADS_BLOCK_ENTRIES];
    logic [23:0] blk_stamp [ADS_BLOCK_ENTRIES];
    logic [3:0]  far_cnt [ADS_SLOT_COUNT];
    logic [4:0]  hs_cnt = '0;
    logic [31:0] linked_id = '0;

    t_acc_word   queued_events [$];
    t_result     expected_actions [$];
    t_acc_word   drv_word = '0;
    int          send_gap = 0;
    int          recv_wait = 0;
    int          hold_left = 0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          send_idle_max = 0;
    int          recv_idle_max = 0;
    int          tick_step_max = 100;
    int          stall_cycles = 0;
    int          mismatch_count = 0;
    logic [23:0] tick_now = '0;
    logic [31:0] id_pool [POOL_SIZE];

    initial begin
        for (int i = 0; i < ADS_BLOCK_ENTRIES; i++) begin
            blk_id[i] = '0;
            blk_stamp[i] = '0;
        end
        for (int i = 0; i < ADS_SLOT_COUNT; i++) begin
            far_cnt[i] = '0;
        end
    end

    function automatic int magnitude(int x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic t_result screen(t_acc_word w);
        t_result     r;
        int          rssi;
        int          ax;
        int          ay;
        int          az;
        logic        found;
        logic        suppressed;
        logic        placed;
        logic [23:0] age;
        r.action = ACT_NONE;
        r.slot = '0;
        r.id = '0;
        r.device = '0;
        r.color = COLOR_WHITE;
        rssi = magnitude(int'(w.rssi));
        ax = int'(w.ax);
        ay = int'(w.ay);
        az = int'(w.az);
        if (!w.req) begin
            if ((cfg_mode == MODE_PASS_ALL || (cfg_mode == MODE_MATCH_ONE && w.dev == cfg_match))
                    && rssi < int'(cfg_sig_limit)) begin
                if (cfg_connect) begin
                    hs_cnt = '0;
                    linked_id = w.id;
                    r.action = ACT_ASSIGN;
                    r.id = w.id;
                end else begin
                    found = 1'b0;
                    suppressed = 1'b0;
                    for (int i = 0; i < ADS_BLOCK_ENTRIES; i++) begin
                        if (!found && blk_id[i] == w.id) begin
                            found = 1'b1;
                            age = w.rtc - blk_stamp[i];
                            if (age >= cfg_ticks) begin
                                blk_id[i] = '0;
                            end else begin
                                suppressed = 1'b1;
                            end
                        end
                    end
                    if (!suppressed) begin
                        placed = 1'b0;
                        for (int i = 0; i < ADS_BLOCK_ENTRIES; i++) begin
                            if (!placed && blk_id[i] == '0) begin
                                placed = 1'b1;
                                blk_id[i] = w.id;
                                blk_stamp[i] = w.rtc;
                            end
                        end
                        r.action = ACT_REPORT;
                        r.id = w.id;
                        r.device = w.dev;
                    end
                end
            end
            return r;
        end
        r.slot = w.slot;
        if (rssi > int'(cfg_sig_limit)) begin
            if (far_cnt[w.slot] != FAR_MAX) begin
                far_cnt[w.slot] = far_cnt[w.slot] + 4'd1;
            end
            if (far_cnt[w.slot] > cfg_far_limit) begin
                r.action = ACT_RELEASE;
                return r;
            end
        end else begin
            far_cnt[w.slot] = '0;
        end
        if (ax == 0 && ay == 0 && az == 0) begin
            r.color = COLOR_WHITE;
        end else if (magnitude(ax) < int'(cfg_accel_limit) && magnitude(az) < int'(cfg_accel_limit)
                && magnitude(ay - int'(cfg_one_g)) < int'(cfg_accel_limit)) begin
            r.color = COLOR_GREEN;
        end else begin
            r.color = COLOR_RED;
        end
        if (hs_cnt != HS_MAX) begin
            hs_cnt = hs_cnt + 5'd1;
        end
        if (hs_cnt == ANNOUNCE_AT) begin
            r.action = ACT_ANNOUNCE;
            r.id = linked_id;
        end else begin
            r.action = ACT_LIGHTS;
        end
        return r;
    endfunction

    function automatic t_acc_word mk_word(logic req, logic [23:0] rtc, logic [7:0] dev,
                                          logic [31:0] id, int rssi, logic [1:0] slot,
                                          int ax, int ay, int az);
        t_acc_word w;
        w.req = req;
        w.rtc = rtc;
        w.dev = dev;
        w.id = id;
        w.rssi = 8'(rssi);
        w.slot = slot;
        w.ax = 8'(ax);
        w.ay = 8'(ay);
        w.az = 8'(az);
        return w;
    endfunction

    function automatic t_acc_word rand_word(int disc_pct);
        t_acc_word w;
        int        m;
        int        lim;
        w.req = ($urandom_range(0, 99) >= disc_pct);
        tick_now = tick_now + 24'($urandom_range(0, tick_step_max));
        w.rtc = ($urandom_range(0, 19) == 0) ? 24'($urandom) : tick_now;
        w.dev = ($urandom_range(0, 2) != 0) ? cfg_match : 8'($urandom);
        w.id = ($urandom_range(0, 4) == 0) ? $urandom : id_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 1) == 0) begin
            w.rssi = 8'($urandom);
        end else begin
            m = int'(cfg_sig_limit) + int'($urandom_range(0, 4)) - 2;
            if (m < 0) m = 0;
            if (m > 128) m = 128;
            w.rssi = ($urandom_range(0, 1) == 0 || m == 128) ? 8'(-m) : 8'(m);
        end
        w.slot = 2'($urandom);
        lim = int'(cfg_accel_limit);
        case ($urandom_range(0, 3))
            0: begin
                w.ax = '0;
                w.ay = '0;
                w.az = '0;
            end
            1: begin
                w.ax = 8'(int'($urandom_range(0, 2 * lim)) - lim);
                w.ay = 8'(int'(cfg_one_g) + int'($urandom_range(0, 2 * lim)) - lim);
                w.az = 8'(int'($urandom_range(0, 2 * lim)) - lim);
            end
            default: begin
                w.ax = 8'($urandom);
                w.ay = 8'($urandom);
                w.az = 8'($urandom);
            end
        endcase
        return w;
    endfunction

    always @(posedge clk) begin : driver
        t_acc_word nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || o_s_tready) begin
            if (s_tvalid) begin
                expected_actions.push_back(screen(drv_word));
            end
            if (send_gap != 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (queued_events.size() != 0) begin
                nxt = queued_events.pop_front();
                drv_word <= nxt;
                s_tdata <= IN_TDATA_W'(nxt[97:0]);
                s_tuser <= nxt.req;
                s_tvalid <= 1'b1;
                send_gap <= $urandom_range(0, send_idle_max);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_result want;
        int      next_wait;
        if (!rst_n) begin
            m_tready <= 1'b0;
            recv_wait <= 0;
            hold_left <= 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (expected_actions.size() == 0) begin
                    $error("unexpected word: action %0d, tdata %h", o_m_tuser, o_m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_actions.pop_front();
                    if (o_m_tuser !== want.action) begin
                        $error("action: expected %0d, actual %0d", want.action, o_m_tuser);
                        mismatch_count++;
                    end
                    if (o_m_tdata[1:0] !== want.slot) begin
                        $error("out_slot: expected %0d, actual %0d", want.slot, o_m_tdata[1:0]);
                        mismatch_count++;
                    end
                    if (o_m_tdata[33:2] !== want.id) begin
                        $error("out_id: expected %h, actual %h", want.id, o_m_tdata[33:2]);
                        mismatch_count++;
                    end
                    if (o_m_tdata[41:34] !== want.device) begin
                        $error("out_device: expected %0d, actual %0d", want.device,
                               o_m_tdata[41:34]);
                        mismatch_count++;
                    end
                    if (o_m_tdata[43:42] !== want.color) begin
                        $error("tilt_color: expected %0d, actual %0d", want.color,
                               o_m_tdata[43:42]);
                        mismatch_count++;
                    end
                end
            end
            if (holds_served != hold_requests) begin
                holds_served <= hold_requests;
                hold_left <= LONG_HOLD;
                m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (o_m_tvalid && m_tready) begin
                next_wait = $urandom_range(0, recv_idle_max);
                recv_wait <= next_wait;
                m_tready <= (next_wait == 0);
            end else if (recv_wait != 0) begin
                recv_wait <= recv_wait - 1;
                m_tready <= (recv_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)
                || (queued_events.size() == 0 && !s_tvalid && expected_actions.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("accessory_discovery_screener: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(t_cfg_addr addr, logic [23:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        case (addr)
            CFG_FILTER_MODE:   cfg_mode = value[1:0];
            CFG_MATCH_DEVICE:  cfg_match = value[7:0];
            CFG_LINK_EN:       cfg_connect = value[0];
            CFG_SIG_LIMIT:     cfg_sig_limit = value[7:0];
            CFG_FAR_LIMIT:     cfg_far_limit = value[3:0];
            CFG_BLOCK_TICKS:   cfg_ticks = value;
            CFG_ACCEL_LIMIT:   cfg_accel_limit = value[7:0];
            CFG_ONE_G:         cfg_one_g = value[6:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(t_filter_mode mode, logic [7:0] match, logic conn,
                                  logic [7:0] sig_lim, logic [3:0] far_lim,
                                  logic [23:0] ticks, logic [7:0] accel_lim, logic [6:0] one_g);
        write_reg(CFG_FILTER_MODE, 24'(mode));
        write_reg(CFG_MATCH_DEVICE, 24'(match));
        write_reg(CFG_LINK_EN, 24'(conn));
        write_reg(CFG_SIG_LIMIT, 24'(sig_lim));
        write_reg(CFG_FAR_LIMIT, 24'(far_lim));
        write_reg(CFG_BLOCK_TICKS, ticks);
        write_reg(CFG_ACCEL_LIMIT, 24'(accel_lim));
        write_reg(CFG_ONE_G, 24'(one_g));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic feed(int count, int disc_pct);
        @(negedge clk);
        repeat (count) queued_events.push_back(rand_word(disc_pct));
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (queued_events.size() != 0 || s_tvalid || expected_actions.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            id_pool[i] = $urandom;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: discovery is filtered out, prop reports run through colors and release.
        @(negedge clk);
        queued_events.push_back(mk_word(1'b0, 24'hFFFFFF, 8'hFF, 32'hFFFFFFFF, 5, 2'd3, 0, 0, 0));
        queued_events.push_back(mk_word(1'b1, 24'h0, 8'h0, 32'h0, 0, 2'd0, 0, 0, 0));
        queued_events.push_back(mk_word(1'b1, 24'h1, 8'h0, 32'h0, -59, 2'd1, 0, 32, 0));
        queued_events.push_back(mk_word(1'b1, 24'h2, 8'h0, 32'h0, 127, 2'd2, -128, 127, -128));
        repeat (6) queued_events.push_back(mk_word(1'b1, 24'h3, 8'h0, 32'h0, -128, 2'd3, 6, 38, -6));
        wait_idle();

        // Scan reporting with a short window: empty-entry id zero, repeats, staleness, full list.
        apply_settings(MODE_PASS_ALL, 8'h00, 1'b0, 8'd59, 4'd5, 24'd1000, 8'd7, 7'd32);
        @(negedge clk);
        queued_events.push_back(mk_word(1'b0, 24'd100, 8'h11, 32'h0, 10, 2'd0, 0, 0, 0));
        queued_events.push_back(mk_word(1'b0, 24'd200, 8'h22, 32'h12345678, -10, 2'd0, 0, 0, 0));
        queued_events.push_back(mk_word(1'b0, 24'd300, 8'h22, 32'h12345678, 58, 2'd0, 0, 0, 0));
        queued_events.push_back(mk_word(1'b0, 24'd1200, 8'h22, 32'h12345678, 0, 2'd0, 0, 0, 0));
        queued_events.push_back(mk_word(1'b0, 24'd1300, 8'h33, 32'h55, -128, 2'd0, 0, 0, 0));
        for (int i = 1; i <= 8; i++) begin
            queued_events.push_back(mk_word(1'b0, 24'(1400 + i), 8'(i), 32'(i), 1, 2'd0, 0, 0, 0));
        end
        wait_idle();

        send_idle_max = 13;
        recv_idle_max = 13;
        tick_step_max = 3000;
        apply_settings(MODE_PASS_ALL, 8'h5A, 1'b1, 8'd59, 4'd5, 24'd9831, 8'd7, 7'd32);
        feed(200, 3);
        wait_idle();

        tick_step_max = 100;
        apply_settings(MODE_MATCH_ONE, 8'hA5, 1'b0, 8'd90, 4'd3, 24'd300, 8'd12, 7'd64);
        feed(250, 85);
        wait_idle();

        // Back-to-back traffic against a long receiver hold so the input side backs up.
        send_idle_max = 0;
        recv_idle_max = 0;
        apply_settings(MODE_PASS_ALL, 8'h00, 1'b0, 8'd128, 4'd14, 24'd0, 8'd128, 7'd127);
        @(negedge clk);
        hold_requests = hold_requests + 1;
        feed(100, 60);
        wait_idle();

        send_idle_max = 13;
        recv_idle_max = 5;
        tick_step_max = 500000;
        apply_settings(MODE_MATCH_ONE, 8'hFF, 1'b0, 8'd0, 4'd0, 24'hFFFFFF, 8'd0, 7'd0);
        feed(100, 50);
        wait_idle();

        send_idle_max = 3;
        recv_idle_max = 13;
        tick_step_max = 100;
        apply_settings(MODE_ADVERTISE, 8'h00, 1'b1, 8'd40, 4'd14, 24'd9831, 8'd128, 7'd127);
        feed(200, 5);
        wait_idle();

        send_idle_max = 13;
        recv_idle_max = 0;
        apply_settings(MODE_MATCH_ONE, 8'h00, 1'b1, 8'd128, 4'd2, 24'd50, 8'd0, 7'd0);
        feed(200, 10);
        wait_idle();

        send_idle_max = 6;
        recv_idle_max = 6;
        tick_step_max = 2000;
        apply_settings(MODE_PASS_ALL, 8'h3C, 1'b0, 8'd59, 4'd5, 24'd5000, 8'd7, 7'd32);
        feed(200, 70);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("accessory_discovery_screener: match");
        end else begin
            $display("accessory_discovery_screener: mismatch");
        end
        $finish;
    end

endmodule
